>>> sv/rc4x_pkg.sv
`timescale 1ns / 1ps

package rc4x_pkg;

   localparam int TABLE_SIZE    = 'h100;
   localparam int BYTE_W        = 8;
   localparam int MAX_KEY_BYTES = 256;
   localparam int KEY_COUNT_W   = 9;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
   localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hff;

   typedef enum logic [1:0] {
      CMD_KEY,
      CMD_KEY_LAST,
      CMD_AUDIO
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [BYTE_W-1:0] value;
      logic              last;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_K_READ,
      ST_K_MIX,
      ST_K_SWAP_A,
      ST_K_SWAP_B,
      ST_T_READ_A,
      ST_T_READ_B,
      ST_T_READ_C,
      ST_T_WRITE
   } back_state_type;

   typedef struct packed {
      logic sched_busy;
      logic table_valid;
   } back_status_type;

endpackage

>>> sv/rc4x_if.sv
`timescale 1ns / 1ps

interface rc4x_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] value;
   logic       last;

   modport source (output valid, output func, output value, output last, input ready);
   modport sink   (input valid, input func, input value, input last, output ready);
endinterface

interface rc4x_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] plain_byte;
   logic       chunk_end;

   modport source (output valid, output plain_byte, output chunk_end, input ready);
   modport sink   (input valid, input plain_byte, input chunk_end, output ready);
endinterface

>>> sv/rc4x_ram.sv
`timescale 1ns / 1ps

module rc4x_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/rc4x_front.sv
`timescale 1ns / 1ps

module rc4x_front (
   input  logic             clock,
   input  logic             reset,
   rc4x_req_if.sink         req_ch,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output rc4x_pkg::cmd_type cmd_data
);
   import rc4x_pkg::*;

   cmd_type             queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   cmd_type             new_cmd;
   logic                push, pop;

   // sort the item into key, final key or audio
   always_comb begin
      new_cmd.value = req_ch.value;
      new_cmd.last  = req_ch.last;
      if (req_ch.func) begin
         new_cmd.kind = CMD_AUDIO;
      end else if (req_ch.last) begin
         new_cmd.kind = CMD_KEY_LAST;
      end else begin
         new_cmd.kind = CMD_KEY;
      end
   end

   assign req_ch.ready = (count_ff != (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;
   assign cmd_valid    = (count_ff != '0);
   assign pop          = cmd_valid && cmd_ready;
   assign cmd_data     = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

>>> sv/rc4x_back.sv
`timescale 1ns / 1ps

module rc4x_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   output logic                      cmd_ready,
   input  rc4x_pkg::cmd_type         cmd_data,
   rc4x_rsp_if.source                rsp_ch,
   output rc4x_pkg::back_status_type status
);
   import rc4x_pkg::*;

   back_state_type          state_ff, state_in;
   logic [BYTE_W-1:0]       idx_ff, idx_in;
   logic [BYTE_W-1:0]       j_ff, j_in;
   logic [BYTE_W-1:0]       kidx_ff, kidx_in;
   logic [BYTE_W-1:0]       si_ff, si_in;
   logic [KEY_COUNT_W-1:0]  key_count_ff, key_count_in;
   logic [BYTE_W-1:0]       offset_ff, offset_in;
   logic                    table_valid_ff, table_valid_in;

   logic                    s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0]       s1_value_ff, s1_value_in;
   logic                    s1_last_ff, s1_last_in;
   logic                    s1_tv_ff, s1_tv_in;
   logic                    out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]       out_byte_ff, out_byte_in;
   logic                    out_last_ff, out_last_in;

   logic                    key_we, key_re;
   logic [BYTE_W-1:0]       key_waddr, key_raddr, key_rdata;
   logic                    perm_we, perm_re;
   logic [BYTE_W-1:0]       perm_waddr, perm_wdata, perm_raddr, perm_rdata;
   logic                    xor_we, xor_re;
   logic [BYTE_W-1:0]       xor_waddr, xor_wdata, xor_raddr, xor_rdata;

   logic                    s1_adv, s1_free;
   logic [BYTE_W-1:0]       j_sum, idx_inc;
   logic [KEY_COUNT_W-1:0]  kidx_next;

   rc4x_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_SIZE)) u_key_ram (
      .clock (clock), .we (key_we), .waddr (key_waddr), .wdata (cmd_data.value),
      .re (key_re), .raddr (key_raddr), .rdata (key_rdata)
   );

   rc4x_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_SIZE)) u_perm_ram (
      .clock (clock), .we (perm_we), .waddr (perm_waddr), .wdata (perm_wdata),
      .re (perm_re), .raddr (perm_raddr), .rdata (perm_rdata)
   );

   rc4x_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_SIZE)) u_xor_ram (
      .clock (clock), .we (xor_we), .waddr (xor_waddr), .wdata (xor_wdata),
      .re (xor_re), .raddr (xor_raddr), .rdata (xor_rdata)
   );

   assign s1_adv    = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign s1_free   = !s1_valid_ff || s1_adv;
   assign j_sum     = j_ff + perm_rdata + key_rdata;
   assign idx_inc   = idx_ff + 1'b1;
   assign kidx_next = {1'b0, kidx_ff} + 1'b1;

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      j_in           = j_ff;
      kidx_in        = kidx_ff;
      si_in          = si_ff;
      key_count_in   = key_count_ff;
      offset_in      = offset_ff;
      table_valid_in = table_valid_ff;
      cmd_ready      = 1'b0;
      key_we         = 1'b0;
      key_waddr      = key_count_ff[BYTE_W-1:0];
      key_re         = 1'b0;
      key_raddr      = kidx_ff;
      perm_we        = 1'b0;
      perm_waddr     = idx_ff;
      perm_wdata     = idx_ff;
      perm_re        = 1'b0;
      perm_raddr     = idx_ff;
      xor_we         = 1'b0;
      xor_waddr      = idx_ff;
      xor_wdata      = perm_rdata;
      xor_re         = 1'b0;
      xor_raddr      = offset_ff;
      // lookup stage keeps its item until the output register frees up
      s1_valid_in    = s1_valid_ff && !s1_adv;
      s1_value_in    = s1_value_ff;
      s1_last_in     = s1_last_ff;
      s1_tv_in       = s1_tv_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd_data.kind)
                  CMD_KEY, CMD_KEY_LAST: begin
                     cmd_ready = 1'b1;
                     if (key_count_ff < KEY_COUNT_W'(MAX_KEY_BYTES)) begin
                        key_we       = 1'b1;
                        key_count_in = key_count_ff + 1'b1;
                     end
                     if (cmd_data.kind == CMD_KEY_LAST) begin
                        state_in = ST_INIT;
                        idx_in   = '0;
                     end
                  end
                  CMD_AUDIO: begin
                     cmd_ready = s1_free;
                     if (s1_free) begin
                        xor_re      = 1'b1;
                        offset_in   = offset_ff + 1'b1;
                        s1_valid_in = 1'b1;
                        s1_value_in = cmd_data.value;
                        s1_last_in  = cmd_data.last;
                        s1_tv_in    = table_valid_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_INIT: begin
            perm_we = 1'b1;
            idx_in  = idx_inc;
            if (idx_ff == BYTE_MASK) begin
               state_in = ST_K_READ;
               j_in     = '0;
               kidx_in  = '0;
            end
         end
         ST_K_READ: begin
            perm_re  = 1'b1;
            key_re   = 1'b1;
            state_in = ST_K_MIX;
         end
         ST_K_MIX: begin
            si_in      = perm_rdata;
            j_in       = j_sum;
            perm_re    = 1'b1;
            perm_raddr = j_sum;
            // key index runs modulo the key length
            if (kidx_next >= key_count_ff) begin
               kidx_in = '0;
            end else begin
               kidx_in = kidx_next[BYTE_W-1:0];
            end
            state_in = ST_K_SWAP_A;
         end
         ST_K_SWAP_A: begin
            perm_we    = 1'b1;
            perm_wdata = perm_rdata;
            state_in   = ST_K_SWAP_B;
         end
         ST_K_SWAP_B: begin
            perm_we    = 1'b1;
            perm_waddr = j_ff;
            perm_wdata = si_ff;
            idx_in     = idx_inc;
            state_in   = (idx_ff == BYTE_MASK) ? ST_T_READ_A : ST_K_READ;
         end
         ST_T_READ_A: begin
            perm_re    = 1'b1;
            perm_raddr = idx_inc;
            state_in   = ST_T_READ_B;
         end
         ST_T_READ_B: begin
            si_in      = perm_rdata;
            perm_re    = 1'b1;
            perm_raddr = perm_rdata + idx_inc;
            state_in   = ST_T_READ_C;
         end
         ST_T_READ_C: begin
            perm_re    = 1'b1;
            perm_raddr = si_ff + perm_rdata;
            state_in   = ST_T_WRITE;
         end
         ST_T_WRITE: begin
            xor_we = 1'b1;
            idx_in = idx_inc;
            if (idx_ff == BYTE_MASK) begin
               state_in       = ST_IDLE;
               table_valid_in = 1'b1;
               offset_in      = '0;
               key_count_in   = '0;
            end else begin
               state_in = ST_T_READ_A;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // output register
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (s1_adv) begin
         out_valid_in = 1'b1;
         out_byte_in  = s1_value_ff ^ (s1_tv_ff ? xor_rdata : '0);
         out_last_in  = s1_last_ff;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.plain_byte = out_byte_ff;
   assign rsp_ch.chunk_end  = out_last_ff;

   assign status.sched_busy  = (state_ff != ST_IDLE);
   assign status.table_valid = table_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         key_count_ff   <= '0;
         offset_ff      <= '0;
         table_valid_ff <= 1'b0;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         key_count_ff   <= key_count_in;
         offset_ff      <= offset_in;
         table_valid_ff <= table_valid_in;
         s1_valid_ff    <= s1_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      j_ff        <= j_in;
      kidx_ff     <= kidx_in;
      si_ff       <= si_in;
      s1_value_ff <= s1_value_in;
      s1_last_ff  <= s1_last_in;
      s1_tv_ff    <= s1_tv_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

endmodule

>>> sv/rc4_variant_xor_stream_decrypt.sv
`timescale 1ns / 1ps

// channel  dir  handshake        payload
// req_ch   in   valid / ready    func, value[7:0], last
// rsp_ch   out  valid / ready    plain_byte[7:0], chunk_end
//
// audio bytes flow at one per cycle while no schedule runs and rsp is not stalled:
// queue, xor table read, output register
// a final key byte starts the schedule in the back end: it fills the permutation,
// then runs the key mix and the table build entry by entry,
// bound by the single read port of the permutation memory
// req_ready stays high until the four-entry queue fills behind a schedule or a
// stalled rsp; reset is synchronous, empties queue and pipeline and marks the table invalid
module rc4_variant_xor_stream_decrypt (
   input  logic       clock,
   input  logic       reset,
   rc4x_req_if.sink   req_ch,
   rc4x_rsp_if.source rsp_ch
);
   import rc4x_pkg::*;

   logic            cmd_valid;
   logic            cmd_ready;
   cmd_type         cmd_data;
   back_status_type status;

   rc4x_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data)
   );

   rc4x_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data),
      .rsp_ch    (rsp_ch),
      .status    (status)
   );

`ifndef SYNTHESIS
   a_no_cmd_while_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && cmd_ready) |-> !status.sched_busy)
      else $error("command taken while schedule runs");

   a_sched_from_last_key: assert property (@(posedge clock) disable iff (reset)
      $rose(status.sched_busy) |->
         $past(cmd_valid && cmd_ready && (cmd_data.kind == CMD_KEY_LAST)))
      else $error("schedule started without a final key byte");

   a_table_after_sched: assert property (@(posedge clock) disable iff (reset)
      $fell(status.sched_busy) |-> status.table_valid)
      else $error("table not marked valid after schedule");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");
`endif

endmodule

>>> tb/rc4_variant_xor_stream_decrypt_tb.sv
`timescale 1ns / 1ps

module rc4_variant_xor_stream_decrypt_tb;
   import rc4x_pkg::*;

   localparam int TARGET_ITEMS = 1850;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int DRAIN_CYCLES = 2400;

   typedef struct packed {
      logic [BYTE_W-1:0] plain_byte;
      logic              chunk_end;
   } plain_item_type;

   class decrypt_scoreboard;
      logic [BYTE_W-1:0] key_bytes [TABLE_SIZE];
      int unsigned       key_len;
      logic [BYTE_W-1:0] perm [TABLE_SIZE];
      logic [BYTE_W-1:0] xor_bytes [TABLE_SIZE];
      logic [BYTE_W-1:0] offset;
      plain_item_type    expected_plain [$];
      int                errors;
      int                keys_loaded;
      int                bytes_checked;

      function new();
         foreach (xor_bytes[n]) begin
            xor_bytes[n] = '0;
            perm[n]      = '0;
            key_bytes[n] = '0;
         end
         key_len       = 0;
         offset        = '0;
         errors        = 0;
         keys_loaded   = 0;
         bytes_checked = 0;
      endfunction

      // key schedule, then table build from the mixed permutation with no further swaps
      function void load_key();
         logic [BYTE_W-1:0] idx;
         logic [BYTE_W-1:0] j;
         logic [BYTE_W-1:0] k;
         logic [BYTE_W-1:0] t;
         logic [BYTE_W-1:0] a;
         logic [BYTE_W-1:0] b;
         logic [BYTE_W-1:0] c;
         for (int n = 0; n < TABLE_SIZE; n++) begin
            idx       = n[BYTE_W-1:0];
            perm[idx] = idx;
         end
         j = '0;
         for (int n = 0; n < TABLE_SIZE; n++) begin
            idx = n[BYTE_W-1:0];
            k = (key_len != 0) ? key_bytes[BYTE_W'(n % key_len)] : '0;
            j = j + perm[idx] + k;
            t = perm[idx];
            perm[idx] = perm[j];
            perm[j] = t;
         end
         for (int n = 0; n < TABLE_SIZE; n++) begin
            idx = n[BYTE_W-1:0];
            a = idx + 1'b1;
            b = perm[a] + a;
            c = perm[a] + perm[b];
            xor_bytes[idx] = perm[c];
         end
         offset  = '0;
         key_len = 0;
         keys_loaded++;
      endfunction

      function void note_input(logic func_bit, logic [BYTE_W-1:0] byte_val, logic last_bit);
         plain_item_type item;
         if (func_bit == 1'b0) begin
            if (key_len < MAX_KEY_BYTES && key_len < TABLE_SIZE) begin
               key_bytes[key_len[BYTE_W-1:0]] = byte_val;
               key_len++;
            end
            if (last_bit) load_key();
         end else begin
            item.plain_byte = byte_val ^ xor_bytes[offset];
            item.chunk_end  = last_bit;
            expected_plain.push_back(item);
            offset = offset + 1'b1;
         end
      endfunction

      function void check_result(logic [BYTE_W-1:0] plain_byte, logic chunk_end);
         plain_item_type item;
         if (expected_plain.size() == 0) begin
            $display("%0t: unexpected output plain_byte %02h chunk_end %0b",
                     $time, plain_byte, chunk_end);
            errors++;
         end else begin
            item = expected_plain.pop_front();
            bytes_checked++;
            if (item.plain_byte !== plain_byte) begin
               $display("%0t: plain_byte mismatch expected %02h actual %02h",
                        $time, item.plain_byte, plain_byte);
               errors++;
            end
            if (item.chunk_end !== chunk_end) begin
               $display("%0t: chunk_end mismatch expected %0b actual %0b",
                        $time, item.chunk_end, chunk_end);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_plain.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   rc4x_req_if req_ch ();
   rc4x_rsp_if rsp_ch ();

   rc4_variant_xor_stream_decrypt i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   decrypt_scoreboard sb = new();

   bit req_quiet;
   bit rsp_quiet;
   int sent_items;
   int overflow_keys;
   int cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap(bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_item(input logic func_bit, input logic [7:0] byte_val,
                            input logic last_bit);
      int gap;
      gap = pick_gap(req_quiet);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         req_ch.func  <= 1'($urandom_range(0, 1));
         req_ch.value <= 8'($urandom_range(0, 255));
         req_ch.last  <= 1'($urandom_range(0, 1));
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func  <= func_bit;
      req_ch.value <= byte_val;
      req_ch.last  <= last_bit;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_input(func_bit, byte_val, last_bit);
      sent_items++;
   endtask

   task automatic send_key(input int len);
      for (int n = 0; n < len; n++) begin
         // stray audio in the middle of a key load
         if ($urandom_range(0, 39) == 0)
            send_item(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         send_item(1'b0, 8'($urandom_range(0, 255)), n == len - 1);
      end
      if (len > MAX_KEY_BYTES) overflow_keys++;
   endtask

   task automatic send_audio(input int len);
      for (int n = 0; n < len; n++)
         send_item(1'b1, 8'($urandom_range(0, 255)),
                   (n == len - 1) || ($urandom_range(0, 15) == 0));
   endtask

   // result side: check each transfer, then decide ready for the next cycle
   initial begin
      int stall;
      stall = 0;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.plain_byte, rsp_ch.chunk_end);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall = pick_gap(rsp_quiet);
         end
         @(posedge clock);
      end
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("status: fail");
      $finish;
   end

   initial begin
      int klen;
      int alen;
      int round;
      int r;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.func  <= 1'b0;
      req_ch.value <= 8'h00;
      req_ch.last  <= 1'b0;
      req_quiet     = 1'b0;
      rsp_quiet     = 1'b0;
      sent_items    = 0;
      overflow_keys = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // audio before any key passes through unchanged
      send_item(1'b1, 8'h00, 1'b0);
      send_item(1'b1, 8'hff, 1'b1);
      send_item(1'b1, 8'ha5, 1'b0);
      // single zero key byte
      send_item(1'b0, 8'h00, 1'b1);
      send_item(1'b1, 8'hff, 1'b0);
      send_item(1'b1, 8'h00, 1'b1);
      // single all-ones key byte, new key right after the last one
      send_item(1'b0, 8'hff, 1'b1);
      send_item(1'b1, 8'h00, 1'b0);
      send_item(1'b1, 8'hff, 1'b1);
      send_item(1'b1, 8'h5a, 1'b0);
      // short key, offset keeps running across chunk ends
      send_item(1'b0, 8'h01, 1'b0);
      send_item(1'b0, 8'h80, 1'b0);
      send_item(1'b0, 8'hff, 1'b1);
      send_item(1'b1, 8'h3c, 1'b1);
      send_item(1'b1, 8'hc3, 1'b0);
      send_item(1'b1, 8'h7e, 1'b1);

      round = 0;
      while (sent_items < TARGET_ITEMS) begin
         req_quiet = ($urandom_range(0, 3) == 0);
         rsp_quiet = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (round == 2) klen = MAX_KEY_BYTES;
         else if (round == 5) klen = $urandom_range(MAX_KEY_BYTES + 1, MAX_KEY_BYTES + 40);
         else if (r < 70) klen = $urandom_range(1, 16);
         else if (r < 90) klen = $urandom_range(17, 64);
         else klen = $urandom_range(65, 255);
         send_key(klen);
         // long bursts wrap the stream offset
         if ($urandom_range(0, 99) < 80) alen = $urandom_range(1, 120);
         else alen = $urandom_range(257, 400);
         send_audio(alen);
         round++;
      end
      req_ch.valid <= 1'b0;

      while (sb.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d input transfers: %0d keys loaded (%0d past capacity)",
               sent_items, sb.keys_loaded, overflow_keys);
      $display("checked %0d decrypted bytes in %0d cycles, %0d mismatches",
               sb.bytes_checked, cycles, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
